/* hw/rtl/ipdd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared widths, register indexes, reset values and the event word that
// travels from the classifier to the frame sequencer.
// ----------------------------------------------------------------------------
package ipdd_pkg;

    // Timer and register widths.
    localparam int TIME_W     = 32;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int BITS_W     = 6;

    // Frame geometry.
    localparam logic [BITS_W-1:0] FRAME_BITS       = 6'd32;
    localparam logic [BITS_W-1:0] LEADER_HOLD_BITS = 6'd16;

    // Input mode codes.
    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_ACK     = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_MIN      = 3'd0,
        CFG_ZERO_MAX      = 3'd1,
        CFG_ONE_MIN       = 3'd2,
        CFG_ONE_MAX       = 3'd3,
        CFG_LEADER_MIN    = 3'd4,
        CFG_LEADER_MAX    = 3'd5,
        CFG_TIMEOUT_ABOVE = 3'd6,
        CFG_NOISE_BELOW   = 3'd7
    } t_cfg_idx;

    // Register reset values in timer ticks.
    localparam logic [TIME_W-1:0] CFG_RESET [NUM_REGS] = '{
        32'd142800, 32'd306000, 32'd346800, 32'd501840,
        32'd1632000, 32'd3060000, 32'd20400000, 32'd40800
    };

    // Interval class, using the priority order of the decoding state.
    typedef enum logic [2:0] {
        CLS_ACK,
        CLS_ZERO,
        CLS_ONE,
        CLS_ABORT,
        CLS_LEADER,
        CLS_NONE
    } t_cls;

    // Classified event word.
    typedef struct packed {
        t_cls kind;
        logic is_leader;
    } t_evt;

    // Frame sequencer states.
    typedef enum logic {
        ST_WAIT,
        ST_DECODE
    } t_dec_state;

endpackage
`default_nettype wire

/* hw/rtl/ipdd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR decoder input channel
// Valid/ready channel carrying one capture or acknowledge word.
// ----------------------------------------------------------------------------
interface ipdd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [ipdd_pkg::TIME_W-1:0] capture_time;

    modport source (output valid, output mode, output capture_time, input ready);
    modport sink   (input valid, input mode, input capture_time, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ipdd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR decoder result channel
// Valid/ready channel carrying one result word per input word.
// ----------------------------------------------------------------------------
interface ipdd_out_if;
    logic                        valid;
    logic                        ready;
    logic [ipdd_pkg::TIME_W-1:0] code;
    logic                        code_ready;
    logic                        code_dropped;
    logic                        busy_res;

    modport source (output valid, output code, output code_ready,
                    output code_dropped, output busy_res, input ready);
    modport sink   (input valid, input code, input code_ready,
                    input code_dropped, input busy_res, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ipdd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR decoder front end
// Holds the threshold registers and the previous timestamp, forms the
// interval of each capture word and classifies it into an event word.
// ----------------------------------------------------------------------------
module ipdd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ipdd_in_if.sink                        i_in,
    input  logic                           i_q_full,
    input  logic                           i_cfg_we,
    input  logic [ipdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipdd_pkg::TIME_W-1:0]    i_cfg_data,
    output logic                           o_push,
    output ipdd_pkg::t_evt                 o_evt
);

    logic [ipdd_pkg::TIME_W-1:0] r_cfg [ipdd_pkg::NUM_REGS];
    logic [ipdd_pkg::TIME_W-1:0] r_prev;
    logic [ipdd_pkg::TIME_W-1:0] w_diff;
    logic [ipdd_pkg::TIME_W-1:0] w_iv;
    logic                        w_in_zero;
    logic                        w_in_one;
    logic                        w_in_leader;
    logic                        w_timeout;
    logic                        w_noise;

    // The queue takes a word whenever it has room.
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Interval since the previous edge; an equal timestamp counts as all ones.
    assign w_diff = i_in.capture_time - r_prev;
    assign w_iv   = (w_diff == '0) ? '1 : w_diff;

    // Range checks against the thresholds.
    assign w_in_zero   = (w_iv >= r_cfg[ipdd_pkg::CFG_ZERO_MIN])
                      && (w_iv <= r_cfg[ipdd_pkg::CFG_ZERO_MAX]);
    assign w_in_one    = (w_iv >= r_cfg[ipdd_pkg::CFG_ONE_MIN])
                      && (w_iv <= r_cfg[ipdd_pkg::CFG_ONE_MAX]);
    assign w_in_leader = (w_iv >= r_cfg[ipdd_pkg::CFG_LEADER_MIN])
                      && (w_iv <= r_cfg[ipdd_pkg::CFG_LEADER_MAX]);
    assign w_timeout   = w_iv > r_cfg[ipdd_pkg::CFG_TIMEOUT_ABOVE];
    assign w_noise     = w_iv < r_cfg[ipdd_pkg::CFG_NOISE_BELOW];

    // Priority classification for the decoding state; the bare leader
    // check is carried alongside for the waiting state.
    always_comb begin
        if (i_in.mode == ipdd_pkg::MODE_ACK) begin
            o_evt.kind = ipdd_pkg::CLS_ACK;
        end else if (w_in_zero) begin
            o_evt.kind = ipdd_pkg::CLS_ZERO;
        end else if (w_in_one) begin
            o_evt.kind = ipdd_pkg::CLS_ONE;
        end else if (w_timeout || w_noise) begin
            o_evt.kind = ipdd_pkg::CLS_ABORT;
        end else if (w_in_leader) begin
            o_evt.kind = ipdd_pkg::CLS_LEADER;
        end else begin
            o_evt.kind = ipdd_pkg::CLS_NONE;
        end
        o_evt.is_leader = w_in_leader;
    end

    // Threshold registers, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ipdd_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= ipdd_pkg::CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Previous timestamp; acknowledge words leave it unchanged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (o_push && (i_in.mode == ipdd_pkg::MODE_CAPTURE)) begin
            r_prev <= i_in.capture_time;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ipdd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR decoder event queue
// Two-entry queue of event words between the classifier and the sequencer.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ipdd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipdd_pkg::t_evt i_evt,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output ipdd_pkg::t_evt o_evt
);

    ipdd_pkg::t_evt r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_evt   = r_mem[r_rd_ptr];

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ipdd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR decoder frame sequencer
// Consumes event words, shifts in data bits, publishes or drops finished
// frames, tracks the busy flag and holds the result register.
// ----------------------------------------------------------------------------
module ipdd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ipdd_pkg::t_evt i_evt,
    output logic           o_pop,
    ipdd_out_if.source     o_out
);

    ipdd_pkg::t_dec_state            r_state;
    ipdd_pkg::t_dec_state            n_state;
    logic [ipdd_pkg::TIME_W-1:0]     r_shift;
    logic [ipdd_pkg::TIME_W-1:0]     n_shift;
    logic [ipdd_pkg::BITS_W-1:0]     r_bits;
    logic [ipdd_pkg::BITS_W-1:0]     n_bits;
    logic [ipdd_pkg::TIME_W-1:0]     r_code;
    logic [ipdd_pkg::TIME_W-1:0]     n_code;
    logic                            r_busy;
    logic                            n_busy;
    logic                            n_ready;
    logic                            n_dropped;

    logic                            r_out_valid;
    logic [ipdd_pkg::TIME_W-1:0]     r_out_code;
    logic                            r_out_ready;
    logic                            r_out_dropped;
    logic                            r_out_busy;

    logic                            w_capture;
    logic                            w_decode;
    logic                            w_take;
    logic                            w_bit;
    logic [ipdd_pkg::BITS_W-1:0]     w_bits_taken;
    logic                            w_start;
    logic                            w_abort;
    logic                            w_done;

    // Take an event when the result register is free or being emptied.
    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    // Event decode against the current state.
    assign w_capture    = o_pop && (i_evt.kind != ipdd_pkg::CLS_ACK);
    assign w_decode     = (r_state == ipdd_pkg::ST_DECODE);
    assign w_take       = w_capture && w_decode
                       && ((i_evt.kind == ipdd_pkg::CLS_ZERO)
                        || (i_evt.kind == ipdd_pkg::CLS_ONE));
    assign w_bit        = (i_evt.kind == ipdd_pkg::CLS_ONE);
    assign w_bits_taken = (r_bits != '0) ? (r_bits - 1'b1) : r_bits;
    assign w_abort      = w_capture && w_decode && (i_evt.kind == ipdd_pkg::CLS_ABORT);
    assign w_done       = w_take && (w_bits_taken == '0);
    assign w_start      = w_capture
                       && ((w_decode && (i_evt.kind == ipdd_pkg::CLS_LEADER)
                            && (r_bits != ipdd_pkg::LEADER_HOLD_BITS))
                        || (!w_decode && i_evt.is_leader));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ipdd_pkg::ST_WAIT: begin
                if (w_start) begin
                    n_state = ipdd_pkg::ST_DECODE;
                end
            end
            ipdd_pkg::ST_DECODE: begin
                if (w_abort || w_done) begin
                    n_state = ipdd_pkg::ST_WAIT;
                end
            end
            default: begin
                n_state = ipdd_pkg::ST_WAIT;
            end
        endcase
    end

    // Frame data, published code, busy flag and result flags.
    always_comb begin
        n_shift   = r_shift;
        n_bits    = r_bits;
        n_code    = r_code;
        n_busy    = r_busy;
        n_ready   = 1'b0;
        n_dropped = 1'b0;
        if (w_take) begin
            n_bits  = w_bits_taken;
            n_shift = {r_shift[ipdd_pkg::TIME_W-2:0], w_bit};
        end
        if (w_start) begin
            n_bits  = ipdd_pkg::FRAME_BITS;
            n_shift = '0;
            n_code  = '0;
        end
        if (w_done) begin
            if (!r_busy) begin
                n_busy  = 1'b1;
                n_code  = n_shift;
                n_ready = 1'b1;
            end else begin
                n_dropped = 1'b1;
            end
        end
        if (o_pop && (i_evt.kind == ipdd_pkg::CLS_ACK)) begin
            n_busy = 1'b0;
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipdd_pkg::ST_WAIT;
            r_shift <= '0;
            r_bits  <= ipdd_pkg::FRAME_BITS;
            r_code  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_code  <= n_code;
            r_busy  <= n_busy;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_code    <= n_code;
            r_out_ready   <= n_ready;
            r_out_dropped <= n_dropped;
            r_out_busy    <= n_busy;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.code         = r_out_code;
    assign o_out.code_ready   = r_out_ready;
    assign o_out.code_dropped = r_out_dropped;
    assign o_out.busy_res     = r_out_busy;

endmodule
`default_nettype wire

/* hw/rtl/ir_pulse_distance_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IR pulse-distance decoder, top level
// Decodes pulse-distance remote frames from falling-edge timestamps.
//
//   Channel  Dir  Handshake      Word
//   i_in     in   valid/ready    mode, capture_time
//   o_out    out  valid/ready    code, code_ready, code_dropped, busy_res
//   cfg      in   i_cfg_we only  i_cfg_idx, i_cfg_data
//
// One word per cycle is sustained while the result side keeps taking words.
// A taken word is classified and written into the queue, the sequencer
// then pops it into the result register, and the result leaves from
// there. The result register and the two-entry queue hold up to three words;
// the input stalls whenever the queue is full.
// Synchronous reset restores the thresholds and clears the frame state.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ipdd_in_if.sink                        i_in,
    ipdd_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [ipdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipdd_pkg::TIME_W-1:0]    i_cfg_data
);

    logic           w_push;
    logic           w_pop;
    logic           w_q_valid;
    logic           w_q_full;
    ipdd_pkg::t_evt w_evt_in;
    ipdd_pkg::t_evt w_evt_out;

    // Classifier.
    ipdd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (w_q_full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push),
        .o_evt      (w_evt_in)
    );

    // Event queue.
    ipdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_evt_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_evt   (w_evt_out)
    );

    // Frame sequencer.
    ipdd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_evt     (w_evt_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    // A taken word is in the queue at the next edge.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_q_valid)
        else $error("accepted word did not reach the queue");

    // A finished frame is either published or dropped, never both.
    a_ready_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.code_ready && o_out.code_dropped))
        else $error("frame both published and dropped");

    // Publishing sets busy, and a drop only happens while busy.
    a_publish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.code_ready || o_out.code_dropped)) |-> o_out.busy_res)
        else $error("frame completion without busy set");

    // The queue never pops when empty.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
